>>> hdl/ngll_pkg.sv
// types, constants and decode functions shared by the gll position parser
`default_nettype none

package ngll_pkg;

	localparam int CHAR_W   = 8;
	localparam int LAT_W    = 20;
	localparam int LON_W    = 24;
	localparam int HEMI_W   = 8;
	localparam int SEEN_W   = 4;
	localparam int OUT_W    = LAT_W + HEMI_W + LON_W + HEMI_W + SEEN_W;

	localparam int HDR_POS_W = 3;
	localparam int COMMA_W   = 3;
	localparam int CIF_W     = 4;
	localparam int DIGIT_W   = 4;
	localparam int IDX_W     = CIF_W + 1;

	// degree part accumulates already scaled by 10000, minutes+fraction in thousandths
	localparam int DEG_W  = 24;
	localparam int NUM_W  = 17;

	// floor(x / 6) = (x * 43691) >> 18, exact for x below 131072
	localparam int                RECIP_W     = 16;
	localparam logic [RECIP_W-1:0] DIV6_RECIP = 16'd43691;
	localparam int                DIV6_SHIFT  = 18;
	localparam int                PROD_W      = NUM_W + RECIP_W;
	localparam int                QUOT_W      = PROD_W - DIV6_SHIFT;

	localparam logic [HDR_POS_W-1:0] HDR_LAST = 3'd5;

	localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UP_G   = 8'h47;
	localparam logic [CHAR_W-1:0] CH_UP_P   = 8'h50;
	localparam logic [CHAR_W-1:0] CH_UP_L   = 8'h4C;

	// field numbers after the header
	localparam logic [COMMA_W-1:0] FLD_LAT  = 3'd1;
	localparam logic [COMMA_W-1:0] FLD_NS   = 3'd2;
	localparam logic [COMMA_W-1:0] FLD_LON  = 3'd3;
	localparam logic [COMMA_W-1:0] FLD_EW   = 3'd4;
	localparam logic [COMMA_W-1:0] FLD_MAX  = 3'd7;

	localparam logic [CIF_W-1:0] CIF_MAX = 4'd15;

	typedef enum logic [2:0] {
		STEP_NONE,
		STEP_DEG,
		STEP_NUM,
		STEP_SKIP,
		STEP_COMMIT
	} step_kind_t;

	typedef struct packed {
		step_kind_t       kind;
		logic [DEG_W-1:0] weight;
	} num_step_t;

	// expected header character at a match position
	function automatic logic [CHAR_W-1:0] hdr_char(input logic [HDR_POS_W-1:0] pos);
		logic [CHAR_W-1:0] ch;
		unique case (pos)
			3'd0:    ch = CH_DOLLAR;
			3'd1:    ch = CH_UP_G;
			3'd2:    ch = CH_UP_P;
			3'd3:    ch = CH_UP_G;
			3'd4:    ch = CH_UP_L;
			3'd5:    ch = CH_UP_L;
			default: ch = CH_DOLLAR;
		endcase
		return ch;
	endfunction

	// digit value, anything that is not a digit counts as zero
	function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] diff;
		diff = c - CH_ZERO;
		return (c >= CH_ZERO && c <= CH_NINE) ? diff[DIGIT_W-1:0] : '0;
	endfunction

	// what a character does at a position of the numeric layout
	// latitude is the longitude layout with one degree digit less
	function automatic num_step_t num_step(input logic is_lon, input logic [CIF_W-1:0] p);
		num_step_t        st;
		logic [IDX_W-1:0] idx;
		idx = is_lon ? IDX_W'(p) : IDX_W'(p) + IDX_W'(1);
		unique case (idx)
			5'd0:    st = '{STEP_DEG,    24'd1000000};
			5'd1:    st = '{STEP_DEG,    24'd100000};
			5'd2:    st = '{STEP_DEG,    24'd10000};
			5'd3:    st = '{STEP_NUM,    24'd10000};
			5'd4:    st = '{STEP_NUM,    24'd1000};
			5'd5:    st = '{STEP_SKIP,   24'd0};
			5'd6:    st = '{STEP_NUM,    24'd100};
			5'd7:    st = '{STEP_NUM,    24'd10};
			5'd8:    st = '{STEP_COMMIT, 24'd1};
			default: st = '{STEP_NONE,   24'd0};
		endcase
		return st;
	endfunction

endpackage

`default_nettype wire

>>> hdl/nmea_gll_position_parser.sv
// top level of the gll sentence parser: header match, field decode, position store
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+---------------------------------------------
//  s       | in  | s_tvalid/tready  | s_tdata: one ascii character
//  m       | out | m_tvalid/tready  | m_tdata: stored position at end of sentence
//
// one character per cycle while s_tready is high; each request is fully processed in the cycle it is accepted
// a result sits in the output register and is shown the cycle after the end character
// s_tready stays high while the output register is empty or being drained this cycle,
// so the stream only stalls when a result is held back by m_tready
// arst_n clears the header search, sentence state and stored positions to zero
`default_nettype none

module nmea_gll_position_parser (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [ngll_pkg::CHAR_W-1:0]  s_tdata,   // [7:0] char_byte

	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [ngll_pkg::OUT_W-1:0]   m_tdata    // [19:0] lat_value, [27:20] lat_hemi,
	                                                // [51:28] lon_value, [59:52] lon_hemi,
	                                                // [63:60] fields_seen
);

	import ngll_pkg::*;

	// header search and sentence control
	logic [HDR_POS_W-1:0] hdr_pos_q, hdr_pos_d;
	logic                 in_sent_q, in_sent_d;
	logic [COMMA_W-1:0]   comma_q, comma_d;
	logic [CIF_W-1:0]     cif_q, cif_d;

	// numeric field accumulators, already weighted by digit position
	logic [DEG_W-1:0]     deg_acc_q, deg_acc_d;
	logic [NUM_W-1:0]     num_acc_q, num_acc_d;

	// committed position and hemispheres, kept across sentences; field flags clear at each header
	logic [LAT_W-1:0]     lat_q, lat_d;
	logic [LON_W-1:0]     lon_q, lon_d;
	logic [HEMI_W-1:0]    lat_hemi_q, lat_hemi_d;
	logic [HEMI_W-1:0]    lon_hemi_q, lon_hemi_d;
	logic [SEEN_W-1:0]    seen_q, seen_d;

	// output register
	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_data_q;

	logic                 accept;
	logic                 emit;
	logic                 end_char;
	logic [COMMA_W-1:0]   comma_inc;
	logic [DIGIT_W-1:0]   digit;
	num_step_t            step;
	logic [DEG_W-1:0]     weighted;
	logic [NUM_W-1:0]     num_final;
	logic [PROD_W-1:0]    div_prod;
	logic [QUOT_W-1:0]    quot;
	logic [DEG_W-1:0]     pos_value;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !out_valid_q || m_tready;

	// '*', control characters and anything above 'z' close the sentence
	assign end_char  = (s_tdata == CH_STAR) || (s_tdata < CH_SPACE) || (s_tdata > CH_LOW_Z);
	assign comma_inc = (comma_q < FLD_MAX) ? comma_q + COMMA_W'(1) : comma_q;

	// digit weighting and the commit value: (minutes*1000 + thousandths)/6 by reciprocal
	assign digit     = digit_of(s_tdata);
	assign step      = num_step(comma_q == FLD_LON, cif_q);
	assign weighted  = DEG_W'(digit) * step.weight;
	assign num_final = num_acc_q + NUM_W'(digit);
	assign div_prod  = PROD_W'(num_final) * PROD_W'(DIV6_RECIP);
	assign quot      = div_prod[DIV6_SHIFT +: QUOT_W];
	assign pos_value = deg_acc_q + DEG_W'(quot);

	always_comb begin
		hdr_pos_d  = hdr_pos_q;
		in_sent_d  = in_sent_q;
		comma_d    = comma_q;
		cif_d      = cif_q;
		deg_acc_d  = deg_acc_q;
		num_acc_d  = num_acc_q;
		lat_d      = lat_q;
		lon_d      = lon_q;
		lat_hemi_d = lat_hemi_q;
		lon_hemi_d = lon_hemi_q;
		seen_d     = seen_q;
		emit       = 1'b0;

		if (accept) begin
			if (!in_sent_q) begin
				// header search, a stray '$' restarts at the second position
				if (s_tdata == hdr_char(hdr_pos_q)) begin
					if (hdr_pos_q == HDR_LAST) begin
						in_sent_d = 1'b1;
						hdr_pos_d = '0;
						comma_d   = '0;
						seen_d    = '0;
						cif_d     = '0;
						deg_acc_d = '0;
						num_acc_d = '0;
					end else begin
						hdr_pos_d = hdr_pos_q + HDR_POS_W'(1);
					end
				end else begin
					hdr_pos_d = (s_tdata == CH_DOLLAR) ? HDR_POS_W'(1) : '0;
				end
			end else if (end_char) begin
				emit      = 1'b1;
				in_sent_d = 1'b0;
				hdr_pos_d = '0;
				cif_d     = '0;
				deg_acc_d = '0;
				num_acc_d = '0;
			end else if (s_tdata == CH_COMMA) begin
				comma_d = comma_inc;
				if (comma_inc >= FLD_LAT && comma_inc <= FLD_EW) begin
					seen_d[2'(comma_inc - COMMA_W'(1))] = 1'b1;
				end
				cif_d     = '0;
				deg_acc_d = '0;
				num_acc_d = '0;
			end else begin
				unique case (comma_q)
					FLD_LAT, FLD_LON: begin
						unique case (step.kind)
							STEP_DEG:    deg_acc_d = deg_acc_q + weighted;
							STEP_NUM:    num_acc_d = num_acc_q + weighted[NUM_W-1:0];
							STEP_COMMIT: begin
								if (comma_q == FLD_LAT) begin
									lat_d = pos_value[LAT_W-1:0];
								end else begin
									lon_d = pos_value;
								end
							end
							default: ;  // decimal point slot or past the layout
						endcase
					end
					FLD_NS: begin
						if (cif_q == '0) begin
							lat_hemi_d = s_tdata;
						end
					end
					FLD_EW: begin
						if (cif_q == '0) begin
							lon_hemi_d = s_tdata;
						end
					end
					default: ;
				endcase
				if (cif_q < CIF_MAX) begin
					cif_d = cif_q + CIF_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q   <= '0;
			in_sent_q   <= 1'b0;
			comma_q     <= '0;
			cif_q       <= '0;
			deg_acc_q   <= '0;
			num_acc_q   <= '0;
			lat_q       <= '0;
			lon_q       <= '0;
			lat_hemi_q  <= '0;
			lon_hemi_q  <= '0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			hdr_pos_q  <= hdr_pos_d;
			in_sent_q  <= in_sent_d;
			comma_q    <= comma_d;
			cif_q      <= cif_d;
			deg_acc_q  <= deg_acc_d;
			num_acc_q  <= num_acc_d;
			lat_q      <= lat_d;
			lon_q      <= lon_d;
			lat_hemi_q <= lat_hemi_d;
			lon_hemi_q <= lon_hemi_d;
			seen_q     <= seen_d;
			// a new result may load while the previous one is drained this cycle
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, the end character itself changes no stored value
	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= {seen_q, lon_hemi_q, lon_q, lat_hemi_q, lat_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

>>> hdl/ngll_checker.sv
// port-level checks for the gll parser, bound to the top level
`default_nettype none

module ngll_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [ngll_pkg::OUT_W-1:0]   m_tdata
);

	// a held result keeps its valid
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result valid dropped while stalled");

	// a held result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result payload changed while stalled");

	// a new result only follows an accepted character
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready))
		else $error("result appeared without an input request");

	// fields open in order, so a later field flag implies the earlier ones
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[63] || m_tdata[62]) && (!m_tdata[62] || m_tdata[61])
			&& (!m_tdata[61] || m_tdata[60]))
		else $error("fields_seen flags out of order");

	// input is taken whenever the output register is free or draining
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input stalled without output backpressure");

endmodule

bind nmea_gll_position_parser ngll_checker u_ngll_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
